// ----- rtl/core/voxel_greedy_mesher_assert.svh -----
// assertion macros for the voxel greedy mesher
// used by rtl/core/voxel_greedy_mesher.sv, expects clk and rst_n in scope
`ifndef VOXEL_GREEDY_MESHER_ASSERT_SVH
`define VOXEL_GREEDY_MESHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define VGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VGM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define VGM_ASSERT(label, prop, msg)
`define VGM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- rtl/core/vgm_pkg.sv -----
// types and codes for the voxel greedy mesher
// no dependencies
package vgm_pkg;

    localparam logic [1:0] OP_LOAD_NODE   = 2'd0;
    localparam logic [1:0] OP_LOAD_BORDER = 2'd1;
    localparam logic [1:0] OP_START       = 2'd2;
    localparam logic [1:0] OP_NEXT_QUAD   = 2'd3;

    localparam logic [1:0] STAT_QUAD     = 2'd0;
    localparam logic [1:0] STAT_DONE     = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] FACE_X_NEG = 3'd0;
    localparam logic [2:0] FACE_X_POS = 3'd1;
    localparam logic [2:0] FACE_Y_NEG = 3'd2;
    localparam logic [2:0] FACE_Y_POS = 3'd3;
    localparam logic [2:0] FACE_Z_NEG = 3'd4;
    localparam logic [2:0] FACE_Z_POS = 3'd5;

    localparam logic [1:0] CFG_AIR    = 2'd0;
    localparam logic [1:0] CFG_IGNORE = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    localparam logic [15:0] AIR_RESET    = 16'd126;
    localparam logic [15:0] IGNORE_RESET = 16'd127;
    localparam logic [14:0] LIMIT_RESET  = 15'd24576;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV0,
        ST_EV1,
        ST_EV2,
        ST_EMIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_SEED,
        PH_GROW_A,
        PH_GROW_B
    } phase_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        chunk_present;
        logic [2:0]  border_face;
        logic [15:0] material_in;
        logic [3:0]  loc_z;
        logic [3:0]  loc_y;
        logic [3:0]  loc_x;
        logic [1:0]  operation;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [1:0]  status;
        logic [15:0] material;
        logic        face_side;
        logic [1:0]  face_axis;
        logic [4:0]  span_a;
        logic [4:0]  span_b;
        logic [3:0]  start_z;
        logic [3:0]  start_y;
        logic [3:0]  start_x;
    } out_item_t;

endpackage

// ----- rtl/core/voxel_greedy_mesher.sv -----
// voxel greedy mesher top level: node and border memories, scan sequencer
// depends on vgm_pkg and voxel_greedy_mesher_assert.svh
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata 32 bits, tuser operation
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata 48 bits, tuser status
// cfg       in   cfg_wr_en                    cfg_addr, cfg_wdata
//
// loads and start are taken and applied in ST_IDLE
// next quad: take the item, then per scanned cell ST_EV0 skips it if visited, else
// reads the single node memory read port; ST_EV1 ends if not solid, else ST_EV2 does
// the full face test; each merge test takes the same path, then ST_EMIT and ST_OUT
// after reset a clearing pass zeroes the border memory while no item is taken;
// a result held at m_axis stalls only the next quad
`include "voxel_greedy_mesher_assert.svh"
module voxel_greedy_mesher
    import vgm_pkg::*;
#(
    parameter int SIDE = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // loc_x, loc_y, loc_z, material_in, border_face, chunk_present
    input  logic [31:0] s_axis_tdata,
    // operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // start_x, start_y, start_z, span_b, span_a, face_axis, face_side, material
    output logic [47:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int LW  = $clog2(SIDE);
    localparam int PC  = SIDE * SIDE;
    localparam int NC  = PC * SIDE;
    localparam int NAW = $clog2(NC);
    localparam int BC  = 6 * PC;
    localparam int BAW = $clog2(BC);
    localparam int HW  = $clog2(SIDE + 1);

    in_item_t in_item;
    assign in_item = in_item_t'({6'b0, s_axis_tdata, s_axis_tuser});

    logic [15:0]    node_mem [NC];
    logic           border_mem [BC];

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [1:0]     axis_reg, axis_next;
    logic           side_reg, side_next;
    logic [LW-1:0]  n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic [LW-1:0]  ea_reg, ea_next, eb_reg, eb_next, da_reg, da_next;
    logic [HW-1:0]  h_reg, h_next, w_reg, w_next;
    logic           end_reg, end_next;
    logic           active_reg, active_next;
    logic [14:0]    qcount_reg, qcount_next;
    logic [15:0]    id_reg, id_next;
    logic           nbb_reg, nbb_next;
    logic [SIDE-1:0] visited_reg [SIDE];
    logic [SIDE-1:0] visited_next [SIDE];
    logic [15:0]    air_reg, ign_reg;
    logic [14:0]    lim_reg;
    out_item_t      res_reg, res_next;
    out_item_t      out_reg;
    logic           out_valid_reg;
    logic [BAW:0]   clr_cnt_reg;
    logic           clr_busy_reg;

    logic           node_re, node_we, bord_re, bord_we;
    logic [NAW-1:0] node_raddr, node_waddr;
    logic [BAW-1:0] bord_raddr, bord_waddr;
    logic           bord_wdata;
    logic [15:0]    node_rd_reg;
    logic           bord_rd_reg;

    logic           in_acc, ev_done, ev_ok, go_b, do_adv;
    logic           last_cell;
    logic [SIDE-1:0] rect_mask [SIDE];

    function automatic logic mat_solid(logic [15:0] m, logic [15:0] air, logic [15:0] ign);
        return (m != air) && (m != ign);
    endfunction

    function automatic logic [NAW-1:0] node_addr(logic [1:0] ax, logic [LW-1:0] pa,
                                                 logic [LW-1:0] pb, logic [LW-1:0] pn);
        int x, y, z;
        case (ax)
            AXIS_X:  begin x = int'(pn); y = int'(pa); z = int'(pb); end
            AXIS_Y:  begin x = int'(pa); y = int'(pn); z = int'(pb); end
            default: begin x = int'(pa); y = int'(pb); z = int'(pn); end
        endcase
        return NAW'((x * SIDE + y) * SIDE + z);
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_reg.material, out_reg.face_side, out_reg.face_axis,
                            out_reg.span_a, out_reg.span_b, out_reg.start_z,
                            out_reg.start_y, out_reg.start_x};
    assign m_axis_tuser  = out_reg.status;

    assign last_cell = (axis_reg == AXIS_Z) && side_reg && (int'(n_reg) == SIDE - 1)
                       && (int'(a_reg) == SIDE - 1) && (int'(b_reg) == SIDE - 1);

    always_comb
    begin
        for (int i = 0; i < SIDE; i++)
        begin
            for (int j = 0; j < SIDE; j++)
            begin
                rect_mask[i][j] = (i >= int'(a_reg)) && (i < int'(a_reg) + int'(h_reg))
                                  && (j >= int'(b_reg))
                                  && (j < int'(b_reg) + int'(w_reg));
            end
        end
    end

    always_comb
    begin
        int ia, ib, wn;
        state_next   = state_reg;
        phase_next   = phase_reg;
        axis_next    = axis_reg;
        side_next    = side_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        da_next      = da_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        end_next     = end_reg;
        active_next  = active_reg;
        qcount_next  = qcount_reg;
        id_next      = id_reg;
        nbb_next     = nbb_reg;
        visited_next = visited_reg;
        res_next     = res_reg;
        node_re      = 1'b0;
        node_we      = 1'b0;
        bord_re      = 1'b0;
        bord_we      = 1'b0;
        node_raddr   = '0;
        node_waddr   = '0;
        bord_raddr   = '0;
        bord_waddr   = '0;
        bord_wdata   = 1'b0;
        ev_done      = 1'b0;
        ev_ok        = 1'b0;
        go_b         = 1'b0;
        do_adv       = 1'b0;
        ia           = 0;
        ib           = 0;
        wn           = 0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_item.operation)
                        OP_LOAD_NODE:
                        begin
                            if ((int'(in_item.loc_x) < SIDE) && (int'(in_item.loc_y) < SIDE)
                                && (int'(in_item.loc_z) < SIDE))
                            begin
                                node_we    = 1'b1;
                                node_waddr = NAW'((int'(in_item.loc_x) * SIDE
                                                   + int'(in_item.loc_y)) * SIDE
                                                  + int'(in_item.loc_z));
                            end
                        end
                        OP_LOAD_BORDER:
                        begin
                            if (in_item.border_face == FACE_X_NEG
                                || in_item.border_face == FACE_X_POS)
                            begin
                                ia = int'(in_item.loc_y);
                                ib = int'(in_item.loc_z);
                            end
                            else if (in_item.border_face == FACE_Y_NEG
                                     || in_item.border_face == FACE_Y_POS)
                            begin
                                ia = int'(in_item.loc_x);
                                ib = int'(in_item.loc_z);
                            end
                            else
                            begin
                                ia = int'(in_item.loc_x);
                                ib = int'(in_item.loc_y);
                            end
                            if ((int'(in_item.border_face) <= int'(FACE_Z_POS))
                                && (ia < SIDE) && (ib < SIDE))
                            begin
                                bord_we    = 1'b1;
                                bord_waddr = BAW'(int'(in_item.border_face) * PC + ia * SIDE + ib);
                                bord_wdata = mat_solid(in_item.material_in, air_reg, ign_reg);
                            end
                        end
                        OP_START:
                        begin
                            qcount_next  = '0;
                            axis_next    = AXIS_X;
                            side_next    = 1'b0;
                            n_next       = '0;
                            a_next       = '0;
                            b_next       = '0;
                            end_next     = 1'b0;
                            visited_next = '{default: '0};
                            active_next  = in_item.chunk_present;
                        end
                        default:
                        begin
                            if (!active_reg || end_reg)
                            begin
                                active_next     = 1'b0;
                                res_next        = '0;
                                res_next.status = STAT_DONE;
                                state_next      = ST_OUT;
                            end
                            else
                            begin
                                phase_next = PH_SEED;
                                ea_next    = a_reg;
                                eb_next    = b_reg;
                                state_next = ST_EV0;
                            end
                        end
                    endcase
                end
            end
            ST_EV0:
            begin
                if (visited_reg[ea_reg][eb_reg])
                begin
                    ev_done = 1'b1;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = node_addr(axis_reg, ea_reg, eb_reg, n_reg);
                    state_next = ST_EV1;
                end
            end
            ST_EV1:
            begin
                if (!mat_solid(node_rd_reg, air_reg, ign_reg)
                    || ((phase_reg != PH_SEED) && (node_rd_reg != id_reg)))
                begin
                    ev_done = 1'b1;
                end
                else
                begin
                    if (phase_reg == PH_SEED)
                    begin
                        id_next = node_rd_reg;
                    end
                    if (!side_reg && (n_reg == '0))
                    begin
                        nbb_next   = 1'b1;
                        bord_re    = 1'b1;
                        bord_raddr = BAW'(int'(axis_reg) * 2 * PC + int'(ea_reg) * SIDE
                                          + int'(eb_reg));
                    end
                    else if (side_reg && (int'(n_reg) == SIDE - 1))
                    begin
                        nbb_next   = 1'b1;
                        bord_re    = 1'b1;
                        bord_raddr = BAW'((int'(axis_reg) * 2 + 1) * PC + int'(ea_reg) * SIDE
                                          + int'(eb_reg));
                    end
                    else
                    begin
                        nbb_next   = 1'b0;
                        node_re    = 1'b1;
                        node_raddr = node_addr(axis_reg, ea_reg, eb_reg,
                                               side_reg ? n_reg + LW'(1) : n_reg - LW'(1));
                    end
                    state_next = ST_EV2;
                end
            end
            ST_EV2:
            begin
                ev_done = 1'b1;
                ev_ok   = nbb_reg ? !bord_rd_reg : !mat_solid(node_rd_reg, air_reg, ign_reg);
            end
            ST_EMIT:
            begin
                if (qcount_reg >= lim_reg)
                begin
                    active_next     = 1'b0;
                    res_next        = '0;
                    res_next.status = STAT_OVERFLOW;
                end
                else
                begin
                    for (int i = 0; i < SIDE; i++)
                    begin
                        visited_next[i] = visited_reg[i] | rect_mask[i];
                    end
                    qcount_next       = qcount_reg + 15'd1;
                    res_next.pad      = '0;
                    res_next.status   = STAT_QUAD;
                    res_next.material = id_reg;
                    res_next.face_side = side_reg;
                    res_next.face_axis = axis_reg;
                    res_next.span_a   = 5'(h_reg);
                    res_next.span_b   = 5'(w_reg);
                    case (axis_reg)
                        AXIS_X:
                        begin
                            res_next.start_x = 4'(n_reg);
                            res_next.start_y = 4'(a_reg);
                            res_next.start_z = 4'(b_reg);
                        end
                        AXIS_Y:
                        begin
                            res_next.start_x = 4'(a_reg);
                            res_next.start_y = 4'(n_reg);
                            res_next.start_z = 4'(b_reg);
                        end
                        default:
                        begin
                            res_next.start_x = 4'(a_reg);
                            res_next.start_y = 4'(b_reg);
                            res_next.start_z = 4'(n_reg);
                        end
                    endcase
                    do_adv = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ev_done)
        begin
            case (phase_reg)
                PH_SEED:
                begin
                    if (ev_ok)
                    begin
                        h_next = HW'(1);
                        if (int'(a_reg) + 1 < SIDE)
                        begin
                            ea_next    = a_reg + LW'(1);
                            eb_next    = b_reg;
                            phase_next = PH_GROW_A;
                            state_next = ST_EV0;
                        end
                        else
                        begin
                            go_b = 1'b1;
                        end
                    end
                    else if (last_cell)
                    begin
                        end_next        = 1'b1;
                        active_next     = 1'b0;
                        res_next        = '0;
                        res_next.status = STAT_DONE;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        do_adv     = 1'b1;
                        state_next = ST_EV0;
                    end
                end
                PH_GROW_A:
                begin
                    if (ev_ok)
                    begin
                        h_next = h_reg + HW'(1);
                        if (int'(a_reg) + int'(h_reg) + 1 < SIDE)
                        begin
                            ea_next    = LW'(int'(a_reg) + int'(h_reg) + 1);
                            state_next = ST_EV0;
                        end
                        else
                        begin
                            go_b = 1'b1;
                        end
                    end
                    else
                    begin
                        go_b = 1'b1;
                    end
                end
                default:
                begin
                    if (ev_ok)
                    begin
                        if (int'(da_reg) + 1 < int'(h_reg))
                        begin
                            da_next    = da_reg + LW'(1);
                            ea_next    = LW'(int'(a_reg) + int'(da_reg) + 1);
                            state_next = ST_EV0;
                        end
                        else
                        begin
                            wn     = int'(w_reg) + 1;
                            w_next = HW'(wn);
                            if (int'(b_reg) + wn < SIDE)
                            begin
                                da_next    = '0;
                                ea_next    = a_reg;
                                eb_next    = LW'(int'(b_reg) + wn);
                                state_next = ST_EV0;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            endcase
        end

        if (go_b)
        begin
            w_next = HW'(1);
            if (int'(b_reg) + 1 < SIDE)
            begin
                da_next    = '0;
                ea_next    = a_reg;
                eb_next    = b_reg + LW'(1);
                phase_next = PH_GROW_B;
                state_next = ST_EV0;
            end
            else
            begin
                state_next = ST_EMIT;
            end
        end

        if (do_adv)
        begin
            if (last_cell)
            begin
                end_next = 1'b1;
            end
            if (int'(b_reg) + 1 < SIDE)
            begin
                b_next = b_reg + LW'(1);
            end
            else
            begin
                b_next = '0;
                if (int'(a_reg) + 1 < SIDE)
                begin
                    a_next = a_reg + LW'(1);
                end
                else
                begin
                    a_next       = '0;
                    visited_next = '{default: '0};
                    if (int'(n_reg) + 1 < SIDE)
                    begin
                        n_next = n_reg + LW'(1);
                    end
                    else
                    begin
                        n_next    = '0;
                        side_next = !side_reg;
                        if (side_reg)
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                end
            end
            ea_next = a_next;
            eb_next = b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SEED;
            axis_reg      <= AXIS_X;
            side_reg      <= 1'b0;
            n_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            end_reg       <= 1'b0;
            active_reg    <= 1'b0;
            qcount_reg    <= '0;
            visited_reg   <= '{default: '0};
            air_reg       <= AIR_RESET;
            ign_reg       <= IGNORE_RESET;
            lim_reg       <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            clr_busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            axis_reg    <= axis_next;
            side_reg    <= side_next;
            n_reg       <= n_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            end_reg     <= end_next;
            active_reg  <= active_next;
            qcount_reg  <= qcount_next;
            visited_reg <= visited_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_AIR:    air_reg <= cfg_wdata;
                    CFG_IGNORE: ign_reg <= cfg_wdata;
                    CFG_LIMIT:  lim_reg <= cfg_wdata[14:0];
                    default:    ;
                endcase
            end
            if ((state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + (BAW + 1)'(1);
                if (int'(clr_cnt_reg) == BC - 1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        da_reg  <= da_next;
        h_reg   <= h_next;
        w_reg   <= w_next;
        id_reg  <= id_next;
        nbb_reg <= nbb_next;
        res_reg <= res_next;
        if ((state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready))
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= in_item.material_in;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            border_mem[clr_cnt_reg[BAW-1:0]] <= 1'b0;
        end
        else if (bord_we)
        begin
            border_mem[bord_waddr] <= bord_wdata;
        end
        if (bord_re)
        begin
            bord_rd_reg <= border_mem[bord_raddr];
        end
    end

    `VGM_ASSERT(a_no_item_in_clear, s_axis_tready |-> !clr_busy_reg, "item taken during clear")
    `VGM_ASSERT(a_emit_spans, (state_reg == ST_EMIT) |-> (h_reg != '0) && (w_reg != '0),
                "empty quad span")
    `VGM_ASSERT(a_status_clean,
                (out_valid_reg && (out_reg.status != STAT_QUAD)) |-> (out_reg.material == '0),
                "status item carries material")
    `VGM_ASSERT_NEXT(a_done_stops, (state_reg == ST_OUT) && (res_reg.status != STAT_QUAD),
                     !active_reg, "build active after end status")

endmodule

// ----- sim/voxel_greedy_mesher_tb.sv -----
// self-checking testbench for voxel_greedy_mesher: stream stimulus, own quad predictor
// depends on vgm_pkg and the rtl top level, no files or arguments
module voxel_greedy_mesher_tb;
    import vgm_pkg::*;

    localparam int N = 16;
    localparam int PLANE = N * N;
    localparam int SCAN_END = 6 * PLANE * N;
    localparam int CYCLE_LIMIT = 8000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    voxel_greedy_mesher dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // mirror of the block state
    logic [15:0] node_mem [N*N*N];
    bit          border_mem [6*PLANE];
    bit          seen_cell [PLANE];
    int unsigned cursor;
    int unsigned quads_out;
    bit          build_on;
    logic [15:0] air_mat;
    logic [15:0] ign_mat;
    logic [14:0] max_quads;

    out_item_t   quad_q[$];
    bit          idle_en;
    int          mismatches;
    int          items_sent;
    int          quads_seen;
    int          done_seen;
    int          overflow_seen;
    int          cycles;
    int          stall_left;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit mat_solid(logic [15:0] m);
        return m != air_mat && m != ign_mat;
    endfunction

    function automatic int node_at(int axis, int a, int b, int n);
        if (axis == AXIS_X)
            return (n * N + a) * N + b;
        else if (axis == AXIS_Y)
            return (a * N + n) * N + b;
        return (a * N + b) * N + n;
    endfunction

    function automatic bit face_here(int axis, int side, int n, int a, int b,
                                     output logic [15:0] m);
        bit beyond;
        m = node_mem[node_at(axis, a, b, n)];
        if (!mat_solid(m))
            return 0;
        if (side == 0)
            beyond = (n == 0) ? border_mem[(axis * 2) * PLANE + a * N + b]
                              : mat_solid(node_mem[node_at(axis, a, b, n - 1)]);
        else
            beyond = (n + 1 >= N) ? border_mem[(axis * 2 + 1) * PLANE + a * N + b]
                                  : mat_solid(node_mem[node_at(axis, a, b, n + 1)]);
        return !beyond;
    endfunction

    function automatic bit joins(int axis, int side, int n, int a, int b,
                                 logic [15:0] id);
        logic [15:0] m;
        if (seen_cell[a * N + b])
            return 0;
        return face_here(axis, side, n, a, b, m) && m == id;
    endfunction

    function automatic void step_cursor();
        cursor++;
        if (cursor % PLANE == 0)
            foreach (seen_cell[i]) seen_cell[i] = 0;
    endfunction

    function automatic out_item_t find_quad();
        out_item_t r;
        int plane, p, n, side, axis, a, b, h, w;
        bit ok;
        logic [15:0] id;
        r = '0;
        while (build_on && cursor < SCAN_END) begin
            plane = cursor / PLANE;
            p = cursor % PLANE;
            n = plane % N;
            side = (plane / N) & 1;
            axis = plane / (2 * N);
            a = p / N;
            b = p % N;
            if (seen_cell[p] || !face_here(axis, side, n, a, b, id)) begin
                step_cursor();
                continue;
            end
            h = 1;
            while (a + h < N && joins(axis, side, n, a + h, b, id))
                h++;
            w = 1;
            while (b + w < N) begin
                ok = 1;
                for (int da = 0; da < h && ok; da++)
                    ok = joins(axis, side, n, a + da, b + w, id);
                if (!ok)
                    break;
                w++;
            end
            if (quads_out >= max_quads) begin
                build_on = 0;
                r.status = STAT_OVERFLOW;
                return r;
            end
            for (int da = 0; da < h; da++)
                for (int db = 0; db < w; db++)
                    seen_cell[(a + da) * N + b + db] = 1;
            quads_out++;
            if (axis == AXIS_X) begin
                r.start_x = 4'(n); r.start_y = 4'(a); r.start_z = 4'(b);
            end
            else if (axis == AXIS_Y) begin
                r.start_x = 4'(a); r.start_y = 4'(n); r.start_z = 4'(b);
            end
            else begin
                r.start_x = 4'(a); r.start_y = 4'(b); r.start_z = 4'(n);
            end
            r.span_b = 5'(w);
            r.span_a = 5'(h);
            r.face_axis = 2'(axis);
            r.face_side = 1'(side);
            r.material = id;
            r.status = STAT_QUAD;
            step_cursor();
            return r;
        end
        build_on = 0;
        r.status = STAT_DONE;
        return r;
    endfunction

    function automatic void apply_item(in_item_t it);
        int a, b;
        case (it.operation)
            OP_LOAD_NODE:
                node_mem[(it.loc_x * N + it.loc_y) * N + it.loc_z] = it.material_in;
            OP_LOAD_BORDER:
                if (it.border_face <= FACE_Z_POS) begin
                    if (it.border_face < FACE_Y_NEG) begin
                        a = int'(it.loc_y); b = int'(it.loc_z);
                    end
                    else if (it.border_face < FACE_Z_NEG) begin
                        a = int'(it.loc_x); b = int'(it.loc_z);
                    end
                    else begin
                        a = int'(it.loc_x); b = int'(it.loc_y);
                    end
                    border_mem[it.border_face * PLANE + a * N + b] = mat_solid(it.material_in);
                end
            OP_START:
            begin
                quads_out = 0;
                cursor = 0;
                foreach (seen_cell[i]) seen_cell[i] = 0;
                build_on = it.chunk_present;
            end
            default:
                quad_q.push_back(find_quad());
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                             logic [15:0] mat, logic [2:0] face, logic present);
        in_item_t it;
        it = '0;
        it.operation = op;
        it.loc_x = x;
        it.loc_y = y;
        it.loc_z = z;
        it.material_in = mat;
        it.border_face = face;
        it.chunk_present = present;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {it.chunk_present, it.border_face, it.material_in,
                        it.loc_z, it.loc_y, it.loc_x};
        s_axis_tuser = it.operation;
        do @(posedge clk); while (!s_axis_tready);
        apply_item(it);
        items_sent++;
    endtask

    task automatic next_quad();
        send_item(OP_NEXT_QUAD, 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                  3'($urandom), 1'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (quad_q.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        case (addr)
            CFG_AIR:    air_mat = data;
            CFG_IGNORE: ign_mat = data;
            CFG_LIMIT:  max_quads = data[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain_build(int most);
        int k;
        k = 0;
        while (build_on && k < most) begin
            next_quad();
            k++;
        end
    endtask

    function automatic logic [15:0] pick_mat();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return air_mat;
            5:             return ign_mat;
            6:             return 16'd5;
            7:             return 16'd9;
            default:       return 16'($urandom);
        endcase
    endfunction

    // requests with no build, absent chunk, ignored border faces
    task automatic test_no_build();
        next_quad();
        send_item(OP_START, 0, 0, 0, 0, FACE_X_NEG, 1'b0);
        next_quad();
        send_item(OP_LOAD_BORDER, 4'hf, 4'hf, 4'hf, 16'hffff, 3'd6, 1'b0);
        send_item(OP_LOAD_BORDER, 4'h0, 4'h0, 4'h0, 16'h0001, 3'd7, 1'b1);
        next_quad();
    endtask

    task automatic test_fill_chunk();
        for (int i = 0; i < N * N * N; i++)
            send_item(OP_LOAD_NODE, 4'(i / PLANE), 4'((i / N) % N), 4'(i % N), AIR_RESET,
                      FACE_X_NEG, 1'b0);
    endtask

    // extreme materials and coordinates, border solidity, long merges
    task automatic test_directed_build();
        send_item(OP_LOAD_NODE, 4'h0, 4'h0, 4'h0, 16'h0000, FACE_X_NEG, 1'b0);
        send_item(OP_LOAD_NODE, 4'hf, 4'hf, 4'hf, 16'hffff, FACE_X_NEG, 1'b0);
        for (int z = 0; z < N; z++)
            send_item(OP_LOAD_NODE, 4'h7, 4'h8, 4'(z), 16'h0005, FACE_X_NEG, 1'b0);
        send_item(OP_LOAD_BORDER, 4'h9, 4'h0, 4'h0, 16'h0003, FACE_X_NEG, 1'b0);
        send_item(OP_LOAD_BORDER, 4'h0, 4'hf, 4'hf, 16'h0003, FACE_Z_POS, 1'b0);
        send_item(OP_LOAD_BORDER, 4'h7, 4'h3, 4'h8, IGNORE_RESET, FACE_Z_NEG, 1'b0);
        send_item(OP_START, 0, 0, 0, 0, FACE_X_NEG, 1'b1);
        drain_build(1000);
    endtask

    task automatic test_registers();
        wait_idle();
        write_reg(CFG_LIMIT, 16'd0);
        send_item(OP_START, 0, 0, 0, 0, FACE_X_NEG, 1'b1);
        drain_build(1000);
        wait_idle();
        write_reg(CFG_LIMIT, 16'd3);
        send_item(OP_START, 0, 0, 0, 0, FACE_X_NEG, 1'b1);
        drain_build(1000);
        wait_idle();
        // everything except the extremes becomes solid
        write_reg(CFG_AIR, 16'h0000);
        write_reg(CFG_IGNORE, 16'hffff);
        write_reg(CFG_LIMIT, {1'b0, LIMIT_RESET});
        send_item(OP_START, 0, 0, 0, 0, FACE_X_NEG, 1'b1);
        drain_build(1000);
        wait_idle();
        write_reg(CFG_AIR, AIR_RESET);
        write_reg(CFG_IGNORE, IGNORE_RESET);
    endtask

    task automatic test_random(int rounds);
        int x0, y0, z0, dx, dy, dz;
        logic [15:0] m;
        for (int r = 0; r < rounds; r++) begin
            if (r >= rounds - 3)
                idle_en = 0;
            wait_idle();
            case ($urandom_range(0, 3))
                0: write_reg(CFG_LIMIT, 16'($urandom_range(0, 12)));
                1: write_reg(CFG_LIMIT, {1'b0, LIMIT_RESET});
                2: write_reg(CFG_AIR, $urandom_range(0, 1) ? AIR_RESET : 16'd9);
                default: write_reg(CFG_IGNORE,
                                   $urandom_range(0, 1) ? IGNORE_RESET : 16'($urandom));
            endcase
            // a box of one material, then scattered nodes and border cells
            x0 = $urandom_range(0, 15); y0 = $urandom_range(0, 15); z0 = $urandom_range(0, 15);
            dx = $urandom_range(1, 3); dy = $urandom_range(1, 3); dz = $urandom_range(1, 3);
            m = $urandom_range(0, 1) ? 16'd5 : 16'($urandom);
            for (int i = x0; i < x0 + dx && i < N; i++)
                for (int j = y0; j < y0 + dy && j < N; j++)
                    for (int k = z0; k < z0 + dz && k < N; k++)
                        send_item(OP_LOAD_NODE, 4'(i), 4'(j), 4'(k), m, 3'($urandom),
                                  1'($urandom));
            repeat ($urandom_range(5, 15))
                send_item(OP_LOAD_NODE, 4'($urandom), 4'($urandom), 4'($urandom), pick_mat(),
                          3'($urandom), 1'($urandom));
            repeat ($urandom_range(2, 8))
                send_item(OP_LOAD_BORDER, 4'($urandom), 4'($urandom), 4'($urandom), pick_mat(),
                          3'($urandom_range(0, 7)), 1'($urandom));
            send_item(OP_START, 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                      3'($urandom), $urandom_range(0, 7) != 0);
            drain_build((r % 3 == 0) ? 1000 : int'($urandom_range(1, 25)));
            // loads while a build is in progress
            if (build_on) begin
                repeat ($urandom_range(1, 4))
                    send_item(OP_LOAD_NODE, 4'($urandom), 4'($urandom), 4'($urandom),
                              pick_mat(), 3'($urandom), 1'($urandom));
                drain_build(int'($urandom_range(1, 10)));
            end
            if ($urandom_range(0, 4) == 0)
                next_quad();
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 18);
        end
    end

    always @(posedge clk)
    begin
        out_item_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = out_item_t'({5'b0, m_axis_tuser, m_axis_tdata[40:0]});
            if (quad_q.size() == 0)
            begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = quad_q.pop_front();
                if (got.status == STAT_QUAD) quads_seen++;
                else if (got.status == STAT_DONE) done_seen++;
                else overflow_seen++;
                if (got.start_x !== want.start_x)
                    begin $error("start_x exp %0d got %0d", want.start_x, got.start_x); mismatches++; end
                if (got.start_y !== want.start_y)
                    begin $error("start_y exp %0d got %0d", want.start_y, got.start_y); mismatches++; end
                if (got.start_z !== want.start_z)
                    begin $error("start_z exp %0d got %0d", want.start_z, got.start_z); mismatches++; end
                if (got.span_b !== want.span_b)
                    begin $error("span_b exp %0d got %0d", want.span_b, got.span_b); mismatches++; end
                if (got.span_a !== want.span_a)
                    begin $error("span_a exp %0d got %0d", want.span_a, got.span_a); mismatches++; end
                if (got.face_axis !== want.face_axis)
                    begin $error("face_axis exp %0d got %0d", want.face_axis, got.face_axis); mismatches++; end
                if (got.face_side !== want.face_side)
                    begin $error("face_side exp %0d got %0d", want.face_side, got.face_side); mismatches++; end
                if (got.material !== want.material)
                    begin $error("material exp %0d got %0d", want.material, got.material); mismatches++; end
                if (got.status !== want.status)
                    begin $error("status exp %0d got %0d", want.status, got.status); mismatches++; end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD_NODE;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_AIR;
        cfg_wdata = '0;
        stall_left = 0;
        idle_en = 1;
        mismatches = 0;
        items_sent = 0;
        quads_seen = 0;
        done_seen = 0;
        overflow_seen = 0;
        cycles = 0;
        foreach (node_mem[i]) node_mem[i] = '0;
        foreach (border_mem[i]) border_mem[i] = 0;
        foreach (seen_cell[i]) seen_cell[i] = 0;
        cursor = 0;
        quads_out = 0;
        build_on = 0;
        air_mat = AIR_RESET;
        ign_mat = IGNORE_RESET;
        max_quads = LIMIT_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_build();
        test_fill_chunk();
        test_directed_build();
        test_registers();
        test_random(14);

        wait_idle();
        $display("sent %0d items; checked %0d quads, %0d done and %0d overflow results",
                 items_sent, quads_seen, done_seen, overflow_seen);
        $display("register settings, ignored loads, partial and full builds were exercised");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
